/* hw/rtl/set_assoc_writeback_lru_cache_unit_assert.svh */
// Assertion macros for the cache unit
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_UNIT_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SAWC_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define SAWC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define SAWC_ASSERT_IMPL(label, clk, rst_n, prop)
`define SAWC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* hw/rtl/sawc_pkg.sv */
`timescale 1ns / 1ps
package sawc_pkg;
	typedef struct packed {
		logic        command;
		logic [16:0] address;
		logic [31:0] write_data;
	} sawc_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        hit;
		logic        misaligned;
		logic        wrote_back;
	} sawc_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WBACK,
		ST_FILL,
		ST_ACCESS,
		ST_DONE
	} sawc_state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic lookup;
		logic wback;
		logic fill_rd;
		logic fill_wr;
		logic access;
		logic respond;
	} sawc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clearing;
		logic misaligned;
		logic hit;
		logic victim_dirty;
	} sawc_stat_t;

	localparam int unsigned CMD_WRITE = 1;
endpackage

/* hw/rtl/sawc_ctrl.sv */
`timescale 1ns / 1ps
module sawc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sawc_pkg::sawc_stat_t stat,
	output sawc_pkg::sawc_cmd_t  cmd,
	output logic                busy
);
	import sawc_pkg::*;

	sawc_state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start && !stat.clearing) state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				if (stat.misaligned || stat.hit) state_d = ST_ACCESS;
				else if (stat.victim_dirty) state_d = ST_WBACK;
				else state_d = ST_FILL;
			end
			ST_WBACK:  state_d = ST_FILL;
			ST_FILL:   state_d = ST_ACCESS;
			ST_ACCESS: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE:   begin
				busy = stat.clearing;
				cmd.latch = start && !stat.clearing;
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				cmd.fill_rd = !(stat.misaligned || stat.hit) && !stat.victim_dirty;
			end
			ST_WBACK:  begin cmd.wback = 1'b1; cmd.fill_rd = 1'b1; end
			ST_FILL:   cmd.fill_wr = 1'b1;
			ST_ACCESS: cmd.access = 1'b1;
			ST_DONE:   cmd.respond = 1'b1;
			default:   cmd = '0;
		endcase
	end
endmodule

/* hw/rtl/sawc_dp.sv */
`timescale 1ns / 1ps
module sawc_dp #(
	parameter int SETS = 8,
	parameter int WAYS = 2,
	parameter int LINE_BYTES = 64,
	parameter int MEM_BYTES = 131072
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sawc_pkg::sawc_in_t   in_item,
	input  sawc_pkg::sawc_cmd_t  cmd,
	output sawc_pkg::sawc_stat_t stat,
	output logic                 result_valid,
	output sawc_pkg::sawc_out_t  result
);
	import sawc_pkg::*;

	localparam int AW = 17;
	localparam int OFFW = $clog2(LINE_BYTES);
	localparam int SETW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int SETB = $clog2(SETS);
	localparam int TAGW = (AW - OFFW - SETB) > 0 ? AW - OFFW - SETB : 1;
	localparam int WAYW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NLINES = SETS * WAYS;
	localparam int LIW = (NLINES > 1) ? $clog2(NLINES) : 1;
	localparam int LBITS = LINE_BYTES * 8;
	localparam int MLINES = MEM_BYTES / LINE_BYTES;
	localparam int MAW = $clog2(MLINES);
	localparam int RKW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WPL = LINE_BYTES / 4;
	localparam int WSW = (WPL > 1) ? $clog2(WPL) : 1;

	// item registers
	sawc_in_t        req_q;
	logic [SETW-1:0] set_q;
	logic [TAGW-1:0] tag_q;
	logic [WAYW-1:0] way_q;
	logic            hit_q, wb_q, mis_q;
	logic [31:0]     rd_q;

	// line stores and per-line state
	logic [LBITS-1:0] data_mem [NLINES];
	logic [TAGW-1:0]  tag_q_arr [WAYS][SETS];
	logic [NLINES-1:0] valid_q, dirty_q;
	logic [RKW-1:0]   rank_q [NLINES];
	logic [LBITS-1:0] bmem [MLINES];
	logic [LBITS-1:0] line_s1, fill_s1;

	// backing memory clear after reset
	logic             clear_q;
	logic [MAW-1:0]   clr_idx_q;

	logic [AW-1:0]    addr;
	logic [SETW-1:0]  set_i;
	logic [TAGW-1:0]  tag_i;

	assign addr = req_q.address;
	always_comb begin
		set_i = '0;
		tag_i = '0;
		if (SETS > 1) set_i = SETW'(addr >> OFFW);
		if (AW - OFFW - SETB > 0) tag_i = TAGW'(addr >> (OFFW + SETB));
	end

	function automatic logic [LIW-1:0] lidx(logic [SETW-1:0] s, logic [WAYW-1:0] w);
		logic [31:0] v;
		v = 32'(s) * 32'(WAYS) + 32'(w);
		return LIW'(v);
	endfunction

	// lookup: hit, free way, LRU way
	logic            f_hit, f_free;
	logic [WAYW-1:0] hit_w, free_w, lru_w, sel_w;
	logic [RKW-1:0]  best;
	always_comb begin
		f_hit = 1'b0; f_free = 1'b0;
		hit_w = '0; free_w = '0; lru_w = '0; best = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (valid_q[lidx(set_i, WAYW'(i))] && tag_q_arr[i][set_i] == tag_i) begin
				f_hit = 1'b1; hit_w = WAYW'(i);
			end
			if (!valid_q[lidx(set_i, WAYW'(i))]) begin
				f_free = 1'b1; free_w = WAYW'(i);
			end
		end
		for (int i = 0; i < WAYS; i++) begin
			if (rank_q[lidx(set_i, WAYW'(i))] >= best) begin
				best = rank_q[lidx(set_i, WAYW'(i))]; lru_w = WAYW'(i);
			end
		end
		sel_w = f_hit ? hit_w : (f_free ? free_w : lru_w);
	end

	assign stat.clearing = clear_q;
	assign stat.misaligned = req_q.address[1:0] != 2'b00;
	assign stat.hit = f_hit;
	assign stat.victim_dirty = !f_hit && !f_free && dirty_q[lidx(set_i, lru_w)];

	// victim line address in backing memory
	logic [MAW-1:0] vaddr, faddr;
	assign faddr = MAW'(addr >> OFFW);
	always_comb begin
		logic [31:0] v;
		v = 32'(tag_q_arr[way_q][set_q]) * 32'(SETS) + 32'(set_q);
		vaddr = MAW'(v);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			clear_q <= 1'b1;
			clr_idx_q <= '0;
			for (int i = 0; i < NLINES; i++) rank_q[i] <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.respond;
			if (clear_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == MAW'(MLINES - 1)) clear_q <= 1'b0;
			end
			if (cmd.fill_wr) begin
				valid_q[lidx(set_q, way_q)] <= 1'b1;
				dirty_q[lidx(set_q, way_q)] <= 1'b0;
			end
			if (cmd.access && !mis_q) begin
				if (req_q.command == 1'(CMD_WRITE)) dirty_q[lidx(set_q, way_q)] <= 1'b1;
				// LRU touch; any fill already left the way at rank 0
				for (int i = 0; i < WAYS; i++) begin
					if (WAYW'(i) != way_q && valid_q[lidx(set_q, WAYW'(i))] &&
					    rank_q[lidx(set_q, WAYW'(i))] < rank_q[lidx(set_q, way_q)])
						rank_q[lidx(set_q, WAYW'(i))] <= rank_q[lidx(set_q, WAYW'(i))] + 1'b1;
				end
				rank_q[lidx(set_q, way_q)] <= '0;
			end
			if (cmd.fill_wr) begin
				// invalid line or dirty victim: every valid other way ages; clean victim: those younger
				for (int i = 0; i < WAYS; i++) begin
					if (WAYW'(i) != way_q && valid_q[lidx(set_q, WAYW'(i))] &&
					    (!hit_q && (wb_q || !valid_q[lidx(set_q, way_q)] ||
					     rank_q[lidx(set_q, WAYW'(i))] < rank_q[lidx(set_q, way_q)])))
						rank_q[lidx(set_q, WAYW'(i))] <= rank_q[lidx(set_q, WAYW'(i))] + 1'b1;
				end
				rank_q[lidx(set_q, way_q)] <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= in_item;
		if (cmd.lookup) begin
			set_q <= set_i;
			tag_q <= tag_i;
			way_q <= sel_w;
			hit_q <= f_hit;
			mis_q <= stat.misaligned;
			wb_q <= stat.victim_dirty;
			rd_q <= '0;
		end
		// a fill hands the new line straight to the access cycle
		if (cmd.fill_wr) line_s1 <= fill_s1;
		else line_s1 <= data_mem[lidx(cmd.lookup ? set_i : set_q, cmd.lookup ? sel_w : way_q)];
		if (cmd.fill_rd) fill_s1 <= bmem[faddr];
		if (clear_q) bmem[clr_idx_q] <= '0;
		else if (cmd.wback) bmem[vaddr] <= line_s1;
		if (cmd.fill_wr) begin
			data_mem[lidx(set_q, way_q)] <= fill_s1;
			tag_q_arr[way_q][set_q] <= tag_q;
		end
		if (cmd.access && !mis_q) begin
			if (req_q.command == 1'(CMD_WRITE)) begin
				logic [LBITS-1:0] nl;
				nl = line_s1;
				nl[32*WSW'(addr[OFFW-1:2]) +: 32] = req_q.write_data;
				data_mem[lidx(set_q, way_q)] <= nl;
			end else begin
				rd_q <= line_s1[32*WSW'(addr[OFFW-1:2]) +: 32];
			end
		end
	end

	assign result.read_data = rd_q;
	assign result.hit = hit_q && !mis_q;
	assign result.misaligned = mis_q;
	assign result.wrote_back = wb_q && !mis_q;
endmodule

/* hw/rtl/set_assoc_writeback_lru_cache_unit.sv */
`timescale 1ns / 1ps
// One word access per item, one result strobed per item. After reset, busy stays
// high while the backing memory (2048 lines at the default sizes) is cleared to
// zero. From the accepted item to its result, a hit or a misaligned access passes
// through the lookup, access and done states; a miss adds a fill state after
// lookup, and a miss that writes back a dirty victim adds a writeback state
// before the fill. busy drops in the cycle of the result strobe, so the next
// item can be accepted with it; the result is shown for exactly one cycle and
// the receiver cannot stall it.
`include "set_assoc_writeback_lru_cache_unit_assert.svh"
module set_assoc_writeback_lru_cache_unit #(
	parameter int SETS = 8,
	parameter int WAYS = 2,
	parameter int LINE_BYTES = 64,
	parameter int MEM_BYTES = 131072
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sawc_pkg::sawc_in_t  request,
	output logic               result_valid,
	output sawc_pkg::sawc_out_t result
);
	import sawc_pkg::*;

	sawc_cmd_t  cmd;
	sawc_stat_t stat;

	sawc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
	);

	sawc_dp #(.SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES), .MEM_BYTES(MEM_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(request), .cmd(cmd), .stat(stat),
		.result_valid(result_valid), .result(result)
	);

	`SAWC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`SAWC_ASSERT_IMPL(a_mis_clean, clk, arst_n, result_valid && result.misaligned |-> result.read_data == 32'd0 && !result.hit && !result.wrote_back)
	`SAWC_ASSERT_IMPL(a_wb_miss, clk, arst_n, result_valid && result.wrote_back |-> !result.hit)
endmodule
